FILE: hdl/vp3th_pkg.sv
package vp3th_pkg;

  localparam int FifoDepth = 4;
  localparam int PtrW = $clog2(FifoDepth);
  localparam int CountW = $clog2(FifoDepth + 1);
  localparam int SumW = CountW + 1;

  localparam logic [4:0] GranuleShiftReset = 5'd15;
  localparam logic [31:0] FrameCounterReset = 32'd1;

  typedef enum logic [1:0] {
    HDR_START,
    HDR_SKIP,
    HDR_TAIL,
    HDR_BODY
  } hdr_pos_t;

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        ends_packet;
    logic [31:0] key_index;
    logic [31:0] since_key;
    logic [4:0]  shift;
    logic [31:0] frame_number;
    logic        eos;
  } stage_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_last;
    logic [62:0] granule_pos;
    logic [31:0] packet_number;
    logic        end_of_stream;
  } result_t;

endpackage

FILE: hdl/vp3th_realign.sv
module vp3th_realign import vp3th_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        key_flag,
  input  logic        frame_last,
  input  logic        stream_end,
  input  logic [4:0]  granule_shift,
  output logic [1:0]  result_count,
  output stage_t      stage
);

  hdr_pos_t    hdr;
  logic [6:0]  residue;
  logic [2:0]  residue_count;
  logic [31:0] frame_counter;
  logic [31:0] frames_since_key;
  logic        first_pending;

  hdr_pos_t    hdr_next;
  logic [15:0] push_val;
  logic [3:0]  push_n;
  logic [15:0] combined;
  logic [3:0]  cnt;
  logic [2:0]  rest;
  logic        drain;
  logic [15:0] drain_shift;
  logic [6:0]  rest_mask;
  logic [6:0]  residue_next;
  logic        pad3;
  logic        flush;
  logic [15:0] flush_shift;
  logic [7:0]  flush_byte;
  logic [1:0]  count_next;
  logic [31:0] fsk_next;
  logic [31:0] fc_next;
  stage_t      stage_next;

  always_comb begin
    unique case (hdr)
      HDR_START: begin
        push_val = {7'b0, 1'b0, in_byte[7], in_byte[5:0], 1'b0};
        push_n   = 4'd9;
        hdr_next = in_byte[7] ? HDR_BODY : HDR_SKIP;
      end
      HDR_SKIP: begin
        push_val = 16'd0;
        push_n   = 4'd0;
        hdr_next = HDR_TAIL;
      end
      HDR_TAIL: begin
        push_val = {13'b0, in_byte[2:0]};
        push_n   = 4'd3;
        hdr_next = HDR_BODY;
      end
      default: begin
        push_val = {8'b0, in_byte};
        push_n   = 4'd8;
        hdr_next = HDR_BODY;
      end
    endcase

    combined     = ({9'b0, residue} << push_n) | push_val;
    cnt          = {1'b0, residue_count} + push_n;
    drain        = cnt[3];
    rest         = cnt[2:0];
    drain_shift  = combined >> rest;
    rest_mask    = (7'd1 << rest) - 7'd1;
    residue_next = combined[6:0] & rest_mask;

    pad3        = (hdr_next == HDR_SKIP) || (hdr_next == HDR_TAIL);
    flush       = frame_last && ((rest != 3'd0) || pad3);
    flush_shift = {9'b0, residue_next} << (4'd8 - {1'b0, rest});
    flush_byte  = flush_shift[7:0];
    count_next  = {1'b0, drain} + {1'b0, flush};

    if (hdr == HDR_START) begin
      fsk_next = (first_pending || key_flag) ? 32'd1 : frames_since_key + 32'd1;
    end else begin
      fsk_next = frames_since_key;
    end
    fc_next = frame_last ? frame_counter + 32'd1 : frame_counter;

    stage_next.first_byte   = drain ? drain_shift[7:0] : flush_byte;
    stage_next.second_byte  = flush_byte;
    stage_next.ends_packet  = frame_last;
    stage_next.key_index    = fc_next - fsk_next - 32'd1;
    stage_next.since_key    = fsk_next - 32'd1;
    stage_next.shift        = granule_shift;
    stage_next.frame_number = fc_next;
    stage_next.eos          = stream_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr              <= HDR_START;
      residue          <= '0;
      residue_count    <= '0;
      frame_counter    <= FrameCounterReset;
      frames_since_key <= '0;
      first_pending    <= 1'b1;
      result_count     <= '0;
    end else begin
      result_count <= accept ? count_next : 2'd0;
      if (accept) begin
        frame_counter    <= fc_next;
        frames_since_key <= fsk_next;
        if (hdr == HDR_START) begin
          first_pending <= 1'b0;
        end
        if (frame_last) begin
          hdr           <= HDR_START;
          residue       <= '0;
          residue_count <= '0;
        end else begin
          hdr           <= hdr_next;
          residue       <= residue_next;
          residue_count <= rest;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

FILE: hdl/vp3th_granule.sv
module vp3th_granule import vp3th_pkg::*; (
  input  logic [1:0] result_count,
  input  stage_t     stage,
  output result_t    wr_first,
  output result_t    wr_second
);

  logic [63:0] granule;
  logic        first_last;

  always_comb begin
    granule    = ({32'b0, stage.key_index} << stage.shift) + {32'b0, stage.since_key};
    first_last = stage.ends_packet && (result_count == 2'd1);

    wr_first.out_byte      = stage.first_byte;
    wr_first.packet_last   = first_last;
    wr_first.granule_pos   = first_last ? granule[62:0] : 63'd0;
    wr_first.packet_number = first_last ? stage.frame_number : 32'd0;
    wr_first.end_of_stream = first_last && stage.eos;

    wr_second.out_byte      = stage.second_byte;
    wr_second.packet_last   = stage.ends_packet;
    wr_second.granule_pos   = stage.ends_packet ? granule[62:0] : 63'd0;
    wr_second.packet_number = stage.ends_packet ? stage.frame_number : 32'd0;
    wr_second.end_of_stream = stage.ends_packet && stage.eos;
  end

endmodule

FILE: hdl/vp3th_out_fifo.sv
module vp3th_out_fifo import vp3th_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        wr_count,
  input  result_t           wr_first,
  input  result_t           wr_second,
  input  logic              pop,
  output logic              rd_valid,
  output result_t           rd_data,
  output logic [CountW-1:0] count
);

  result_t         entries [FifoDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;

  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(wr_count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count + CountW'(wr_count) - CountW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      entries[wr_ptr] <= wr_first;
    end
    if (wr_count[1]) begin
      entries[wr_ptr + PtrW'(1)] <= wr_second;
    end
  end

endmodule

FILE: hdl/vp3_to_theora_frame_rewriter_top.sv
// Rewrites a VP3 frame, fed one byte per transaction MSB first, into Theora
// packet bytes. One input byte is taken per clock cycle unless in_ready holds
// the input off; each byte yields zero, one or two output bytes, which are
// registered in the realignment stage, pass the combinational granule stage
// and are written into a four-entry output queue. A frame's last byte always
// yields at least one output byte, carrying packet_last with granule_pos,
// packet_number and end_of_stream; those three fields read zero on every other
// byte. The input is held off whenever the output queue plus the granule stage
// could not absorb two more bytes, so the output side, at one byte per cycle
// while out_ready is high, sets the sustained rate when realignment produces
// extra bytes. granule_shift is written on the configuration channel, always
// ready, and must only change between frames while no bytes are in flight.
module vp3_to_theora_frame_rewriter_top import vp3th_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        key_flag,
  input  logic        frame_last,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        packet_last,
  output logic [62:0] granule_pos,
  output logic [31:0] packet_number,
  output logic        end_of_stream
);

  logic [4:0]        granule_shift;
  logic              accept;
  logic [1:0]        stage_count;
  stage_t            stage;
  result_t           wr_first;
  result_t           wr_second;
  result_t           rd_data;
  logic [CountW-1:0] fifo_count;
  logic [SumW-1:0]   pending;

  assign cfg_ready = 1'b1;
  assign pending   = {1'b0, fifo_count} + SumW'(stage_count);
  assign in_ready  = (pending <= SumW'(FifoDepth - 2));
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      granule_shift <= GranuleShiftReset;
    end else if (cfg_valid && cfg_ready) begin
      granule_shift <= cfg_data;
    end
  end

  vp3th_realign u_realign (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (in_byte),
    .key_flag      (key_flag),
    .frame_last    (frame_last),
    .stream_end    (stream_end),
    .granule_shift (granule_shift),
    .result_count  (stage_count),
    .stage         (stage)
  );

  vp3th_granule u_granule (
    .result_count (stage_count),
    .stage        (stage),
    .wr_first     (wr_first),
    .wr_second    (wr_second)
  );

  vp3th_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_count  (stage_count),
    .wr_first  (wr_first),
    .wr_second (wr_second),
    .pop       (out_valid && out_ready),
    .rd_valid  (out_valid),
    .rd_data   (rd_data),
    .count     (fifo_count)
  );

  assign out_byte      = rd_data.out_byte;
  assign packet_last   = rd_data.packet_last;
  assign granule_pos   = rd_data.granule_pos;
  assign packet_number = rd_data.packet_number;
  assign end_of_stream = rd_data.end_of_stream;

  assert property (@(posedge clk) disable iff (rst)
    pending <= SumW'(FifoDepth))
    else $error("output queue overrun");

  assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |=> stage_count != 2'd0)
    else $error("frame end produced no output byte");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_last |-> granule_pos == 63'd0 && packet_number == 32'd0
      && !end_of_stream)
    else $error("frame fields set on a byte that does not end the packet");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import vp3th_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        key_flag = 1'b0;
  logic        frame_last = 1'b0;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        packet_last;
  logic [62:0] granule_pos;
  logic [31:0] packet_number;
  logic        end_of_stream;

  vp3_to_theora_frame_rewriter_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .key_flag      (key_flag),
    .frame_last    (frame_last),
    .stream_end    (stream_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .packet_last   (packet_last),
    .granule_pos   (granule_pos),
    .packet_number (packet_number),
    .end_of_stream (end_of_stream)
  );

  always #1 clk = ~clk;

  // Rewriter state mirrored by the predictor
  logic [15:0] res_bits;
  int unsigned res_count;
  hdr_pos_t    hdr_pos;
  logic [31:0] frame_count;
  logic [31:0] since_key;
  logic        first_pending;
  logic [4:0]  shift_val;

  result_t     step_out[$];
  result_t     expected_bytes[$];
  result_t     want;
  logic [7:0]  frame_buf[$];

  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          bytes_checked = 0;
  int          packets_checked = 0;
  int          shifts_used = 0;
  int          fail_count = 0;
  int          reported = 0;
  int          ready_left = 0;
  logic        back_to_back = 1'b0;

  function automatic void reset_rewriter_state();
    res_bits = '0;
    res_count = 0;
    hdr_pos = HDR_START;
    frame_count = FrameCounterReset;
    since_key = '0;
    first_pending = 1'b1;
    shift_val = GranuleShiftReset;
  endfunction

  function automatic void push_bits(logic [7:0] value, int unsigned n);
    res_bits = 16'((res_bits << n) | (value & 8'((1 << n) - 1)));
    res_count += n;
  endfunction

  function automatic void drain_full_bytes();
    int unsigned rest;
    result_t     r;
    while (res_count >= 8) begin
      rest = res_count - 8;
      r = '0;
      r.out_byte = 8'(res_bits >> rest);
      step_out.push_back(r);
      res_count = rest;
      res_bits = res_bits & 16'((1 << rest) - 1);
    end
  endfunction

  function automatic void predict_packet_bytes(logic [7:0] b, logic key, logic last,
                                               logic eos);
    logic [31:0] key_index;
    logic [31:0] since;
    logic [63:0] gran;
    result_t     r;
    step_out.delete();
    case (hdr_pos)
      HDR_START: begin
        if (first_pending) begin
          first_pending = 1'b0;
          since_key = 32'd1;
        end else if (key) begin
          since_key = 32'd1;
        end else begin
          since_key = since_key + 32'd1;
        end
        push_bits(8'd0, 1);
        push_bits({7'd0, b[7]}, 1);
        push_bits(b, 6);
        push_bits(8'd0, 1);
        hdr_pos = b[7] ? HDR_BODY : HDR_SKIP;
      end
      HDR_SKIP: hdr_pos = HDR_TAIL;
      HDR_TAIL: begin
        push_bits(b, 3);
        hdr_pos = HDR_BODY;
      end
      default: push_bits(b, 8);
    endcase
    drain_full_bytes();
    if (last) begin
      if (hdr_pos == HDR_SKIP || hdr_pos == HDR_TAIL) push_bits(8'd0, 3);
      drain_full_bytes();
      if (res_count > 0) begin
        res_bits = (res_bits << (8 - res_count)) & 16'h00FF;
        res_count = 8;
        drain_full_bytes();
      end
      frame_count = frame_count + 32'd1;
      key_index = frame_count - since_key - 32'd1;
      since = since_key - 32'd1;
      gran = ({32'd0, key_index} << shift_val) + {32'd0, since};
      r = step_out[step_out.size() - 1];
      r.packet_last = 1'b1;
      r.granule_pos = gran[62:0];
      r.packet_number = frame_count;
      r.end_of_stream = eos;
      step_out[step_out.size() - 1] = r;
      res_bits = '0;
      res_count = 0;
      hdr_pos = HDR_START;
    end
    foreach (step_out[i]) expected_bytes.push_back(step_out[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (back_to_back || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic key, input logic last,
                           input logic eos);
    in_valid   <= 1'b1;
    in_byte    <= b;
    key_flag   <= key;
    frame_last <= last;
    stream_end <= eos;
    do @(posedge clk); while (!in_ready);
    predict_packet_bytes(b, key, last, eos);
    bytes_sent++;
    if (last) frames_sent++;
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Key flag counts on the first byte only; stream end only with the last byte
  task automatic send_frame(input logic key, input logic eos);
    int n;
    n = frame_buf.size();
    for (int i = 0; i < n; i++) begin
      send_byte(frame_buf[i], (i == 0) ? key : 1'($urandom_range(0, 1)), i == n - 1,
                (i == n - 1) ? eos : 1'($urandom_range(0, 1)));
      idle_input(pick_gap());
    end
  endtask

  task automatic wait_drained();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_shift(input logic [4:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shift_val = v;
    shifts_used++;
  endtask

  task automatic test_first_frame_inter();
    frame_buf = '{8'hC5, 8'h12, 8'h34};
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_intra_header();
    frame_buf = '{8'h00, 8'hFF, 8'hFF, 8'hA5, 8'h3C};
    send_frame(1'b1, 1'b0);
  endtask

  task automatic test_short_intra();
    frame_buf = '{8'h3F};
    send_frame(1'b1, 1'b0);
    frame_buf = '{8'h7F, 8'hFF};
    send_frame(1'b0, 1'b0);
    frame_buf = '{8'h15, 8'hAA, 8'h5B};
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_flag_mismatch();
    frame_buf = '{8'hFF, 8'h00};
    send_frame(1'b1, 1'b0);
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'hFF};
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_stream_end();
    frame_buf = '{8'hFF};
    send_frame(1'b0, 1'b1);
    frame_buf = '{8'h81, 8'hFF};
    send_frame(1'b0, 1'b0);
    frame_buf = '{8'h00};
    send_frame(1'b1, 1'b1);
  endtask

  task automatic test_random_frames(input logic [4:0] shift, input int n_bytes);
    int stop_at;
    int len;
    int r;
    write_shift(shift);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 15) len = $urandom_range(1, 3);
      else if (r < 85) len = $urandom_range(4, 12);
      else len = $urandom_range(13, 40);
      frame_buf.delete();
      repeat (len) frame_buf.push_back(8'($urandom));
      send_frame($urandom_range(0, 9) < 3, $urandom_range(0, 4) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_left <= 0;
    end else if (ready_left == 0) begin
      if (back_to_back || $urandom_range(0, 2) != 0) begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(1, 8);
      end else begin
        out_ready  <= 1'b0;
        ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      bytes_checked++;
      if (packet_last) packets_checked++;
      if (expected_bytes.size() == 0) begin
        fail_count++;
        reported++;
        if (reported <= 10)
          $display("%0t: unexpected transaction: byte %h last %b granule %h number %h eos %b",
                   $realtime, out_byte, packet_last, granule_pos, packet_number,
                   end_of_stream);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.out_byte || packet_last !== want.packet_last ||
            granule_pos !== want.granule_pos || packet_number !== want.packet_number ||
            end_of_stream !== want.end_of_stream) begin
          fail_count++;
          reported++;
          if (reported <= 10) begin
            $display("%0t: mismatch, expected byte %h last %b granule %h number %h eos %b",
                     $realtime, want.out_byte, want.packet_last, want.granule_pos,
                     want.packet_number, want.end_of_stream);
            $display("%0t:           actual byte %h last %b granule %h number %h eos %b",
                     $realtime, out_byte, packet_last, granule_pos, packet_number,
                     end_of_stream);
          end
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int waited;
    reset_rewriter_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_first_frame_inter();
    test_intra_header();
    test_short_intra();
    test_flag_mismatch();
    test_stream_end();

    test_random_frames(5'd0, 210);
    test_random_frames(5'd31, 210);
    back_to_back = 1'b1;
    test_random_frames(5'($urandom_range(1, 30)), 210);
    back_to_back = 1'b0;
    test_random_frames(GranuleShiftReset, 210);

    in_valid <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      fail_count++;
      $display("%0d expected packet bytes never arrived", expected_bytes.size());
    end

    $display("Fed %0d VP3 bytes in %0d frames across %0d granule shift settings.",
             bytes_sent, frames_sent, shifts_used + 1);
    $display("Checked %0d packet bytes and %0d packet ends; %0d failures.",
             bytes_checked, packets_checked, fail_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
